// File: hw/rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared constants, types and the Morse code table for the key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int MAX_SYMBOLS   = 6;
  localparam int TABLE_ENTRIES = 36;
  localparam int ROM_SIZE      = 36;

  localparam int CNT_W  = 18;
  localparam int THR_W  = 16;
  localparam int SCNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int ROM_AW = (ROM_SIZE > 1) ? $clog2(ROM_SIZE) : 1;
  localparam int TAB_CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_W  = 4;
  localparam int DASH_W = 8;
  localparam int CHAR_W = 7;

  localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_RESET    = 16'd200;
  localparam logic [CHAR_W-1:0] UNKNOWN_CHAR = 7'h3F;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii;
    logic [LEN_W-1:0]  len;
    logic [DASH_W-1:0] dashes;  // bit i set: symbol i is a dash
  } rom_entry_t;

  // one result item as it leaves the decoder
  typedef struct packed {
    logic [CHAR_W-1:0] letter;
    logic              letter_valid;
    logic              led_on;
  } result_t;

  function automatic rom_entry_t code_rom_at(input logic [ROM_AW-1:0] idx);
    rom_entry_t e;
    case (idx)
      6'd0:    e = '{7'h41, 4'd2, 8'h02};
      6'd1:    e = '{7'h42, 4'd4, 8'h01};
      6'd2:    e = '{7'h43, 4'd4, 8'h05};
      6'd3:    e = '{7'h44, 4'd3, 8'h01};
      6'd4:    e = '{7'h45, 4'd1, 8'h00};
      6'd5:    e = '{7'h46, 4'd4, 8'h04};
      6'd6:    e = '{7'h47, 4'd3, 8'h03};
      6'd7:    e = '{7'h48, 4'd4, 8'h00};
      6'd8:    e = '{7'h49, 4'd2, 8'h00};
      6'd9:    e = '{7'h4A, 4'd4, 8'h0E};
      6'd10:   e = '{7'h4B, 4'd3, 8'h05};
      6'd11:   e = '{7'h4C, 4'd4, 8'h02};
      6'd12:   e = '{7'h4D, 4'd2, 8'h03};
      6'd13:   e = '{7'h4E, 4'd2, 8'h01};
      6'd14:   e = '{7'h4F, 4'd3, 8'h07};
      6'd15:   e = '{7'h50, 4'd4, 8'h06};
      6'd16:   e = '{7'h51, 4'd4, 8'h0B};
      6'd17:   e = '{7'h52, 4'd3, 8'h02};
      6'd18:   e = '{7'h53, 4'd3, 8'h00};
      6'd19:   e = '{7'h54, 4'd1, 8'h01};
      6'd20:   e = '{7'h55, 4'd3, 8'h04};
      6'd21:   e = '{7'h56, 4'd4, 8'h08};
      6'd22:   e = '{7'h57, 4'd3, 8'h06};
      6'd23:   e = '{7'h58, 4'd4, 8'h09};
      6'd24:   e = '{7'h59, 4'd4, 8'h0D};
      6'd25:   e = '{7'h5A, 4'd4, 8'h03};
      6'd26:   e = '{7'h30, 4'd5, 8'h1F};
      6'd27:   e = '{7'h31, 4'd5, 8'h1E};
      6'd28:   e = '{7'h32, 4'd5, 8'h1C};
      6'd29:   e = '{7'h33, 4'd5, 8'h18};
      6'd30:   e = '{7'h34, 4'd5, 8'h10};
      6'd31:   e = '{7'h35, 4'd5, 8'h00};
      6'd32:   e = '{7'h36, 4'd5, 8'h01};
      6'd33:   e = '{7'h37, 4'd5, 8'h03};
      6'd34:   e = '{7'h38, 4'd5, 8'h07};
      6'd35:   e = '{7'h39, 4'd5, 8'h0F};
      default: e = '{UNKNOWN_CHAR, 4'd0, 8'h00};  // len 0 never matches
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/mkd_code_rom.sv
// ----------------------------------------------------------------------------
// mkd_code_rom
// Synchronous Morse code table, one entry read per cycle, registered data.
// ----------------------------------------------------------------------------
module mkd_code_rom (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [mkd_pkg::ROM_AW-1:0] rd_addr,
  output mkd_pkg::rom_entry_t       rd_data
);
  import mkd_pkg::*;

  rom_entry_t mem [ROM_SIZE];
  rom_entry_t rd_data_r;

  always_comb begin
    for (int i = 0; i < ROM_SIZE; i++) begin
      mem[i] = code_rom_at(ROM_AW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/mkd_ctrl.sv
// ----------------------------------------------------------------------------
// mkd_ctrl
// Per-tick key state update and table walk sequencer.
// ----------------------------------------------------------------------------
module mkd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mkd_pkg::THR_W-1:0]   threshold,
  input  logic                        key_vld,
  input  logic                        key_pressed,
  output logic                        key_rdy,
  input  logic                        out_free,
  output logic                        res_vld,
  output mkd_pkg::result_t            res,
  output logic                        rom_rd_en,
  output logic [mkd_pkg::ROM_AW-1:0]  rom_rd_addr,
  input  mkd_pkg::rom_entry_t         rom_rd_data
);
  import mkd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic                    holding_r, holding_nxt;
  logic [CNT_W-1:0]        hold_r, hold_nxt;
  logic [CNT_W-1:0]        gap_r, gap_nxt;
  logic [MAX_SYMBOLS-1:0]  sym_r, sym_nxt;
  logic [SCNT_W-1:0]       scnt_r, scnt_nxt;
  logic [MAX_SYMBOLS-1:0]  srch_sym_r, srch_sym_nxt;
  logic [SCNT_W-1:0]       srch_cnt_r, srch_cnt_nxt;
  logic [TAB_CW-1:0]       addr_r, addr_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [CHAR_W-1:0]       ch_r, ch_nxt;

  logic                    accept;
  logic [CNT_W-1:0]        hold_inc;
  logic [CNT_W-1:0]        gap_inc;
  logic [CNT_W-1:0]        gap_limit;
  logic                    released;
  logic                    is_dash;
  logic                    fire;
  logic                    match;

  assign key_rdy   = (state_r == ST_IDLE) && out_free;
  assign accept    = key_vld && key_rdy;
  assign gap_limit = (CNT_W'(threshold) << 1) + CNT_W'(threshold);
  assign hold_inc  = (hold_r == CNT_MAX) ? hold_r : hold_r + 1'b1;
  assign gap_inc   = (gap_r == CNT_MAX) ? gap_r : gap_r + 1'b1;
  assign match     = cmp_vld_r
                   && (rom_rd_data.len == LEN_W'(srch_cnt_r))
                   && (rom_rd_data.dashes == DASH_W'(srch_sym_r));

  assign rom_rd_en   = (state_r == ST_SEARCH) && (addr_r < TAB_CW'(TABLE_ENTRIES));
  assign rom_rd_addr = ROM_AW'(addr_r);

  always_comb begin
    state_nxt    = state_r;
    holding_nxt  = holding_r;
    hold_nxt     = hold_r;
    gap_nxt      = gap_r;
    sym_nxt      = sym_r;
    scnt_nxt     = scnt_r;
    srch_sym_nxt = srch_sym_r;
    srch_cnt_nxt = srch_cnt_r;
    addr_nxt     = addr_r;
    cmp_vld_nxt  = 1'b0;
    ch_nxt       = ch_r;
    released     = 1'b0;
    is_dash      = 1'b0;
    fire         = 1'b0;
    res_vld      = 1'b0;
    res          = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (holding_r) begin
            hold_nxt = hold_inc;
          end
          if (key_pressed && !holding_r) begin
            holding_nxt = 1'b1;
            hold_nxt    = '0;
          end else if (!key_pressed && holding_r) begin
            is_dash     = !(hold_inc < CNT_W'(threshold));
            holding_nxt = 1'b0;
            gap_nxt     = '0;
            released    = 1'b1;
            if (scnt_r < SCNT_W'(MAX_SYMBOLS)) begin
              sym_nxt  = sym_r | (MAX_SYMBOLS'(is_dash) << scnt_r);
              scnt_nxt = scnt_r + 1'b1;
            end
          end
          if (!holding_nxt && !released) begin
            gap_nxt = gap_inc;
            fire    = (gap_inc > gap_limit) && (scnt_r != '0);
          end
          if (fire) begin
            // pattern moves to the search registers, walk starts at entry 0
            srch_sym_nxt = sym_r;
            srch_cnt_nxt = scnt_r;
            sym_nxt      = '0;
            scnt_nxt     = '0;
            addr_nxt     = '0;
            state_nxt    = ST_SEARCH;
          end else begin
            res_vld    = 1'b1;
            res.led_on = holding_nxt;
          end
        end
      end
      ST_SEARCH: begin
        if (rom_rd_en) begin
          addr_nxt    = addr_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
        if (match) begin
          ch_nxt    = rom_rd_data.ascii;
          state_nxt = ST_DONE;
        end else if (!cmp_vld_r && !rom_rd_en) begin
          ch_nxt    = UNKNOWN_CHAR;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_vld          = 1'b1;
          res.letter_valid = 1'b1;
          res.letter       = ch_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      holding_r  <= 1'b0;
      hold_r     <= '0;
      gap_r      <= '0;
      sym_r      <= '0;
      scnt_r     <= '0;
      cmp_vld_r  <= 1'b0;
      addr_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      holding_r  <= holding_nxt;
      hold_r     <= hold_nxt;
      gap_r      <= gap_nxt;
      sym_r      <= sym_nxt;
      scnt_r     <= scnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      addr_r     <= addr_nxt;
    end
    srch_sym_r <= srch_sym_nxt;
    srch_cnt_r <= srch_cnt_nxt;
    ch_r       <= ch_nxt;
  end

endmodule

// File: hw/rtl/morse_key_decoder.sv
// A tick that decodes no letter has its result registered in the cycle after it is taken.
// A tick that closes a letter walks the code table, one entry per cycle from the synchronous
// ROM until a match or the table end (36 entries), then waits for a free output register.
// Throughput: one tick at a time; the next waits for its result and a free output register.
// Reset: synchronous active-low rst_n clears key state, pattern and output valid;
// threshold returns to 200.
// ----------------------------------------------------------------------------
// morse_key_decoder
// Morse key decoder: times key holds and gaps, walks the code table per letter.
// ----------------------------------------------------------------------------
module morse_key_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // threshold_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [0] key_pressed, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [0] led_on, [1] letter_valid, [8:2] letter, [15:9] zero
);
  import mkd_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic              out_vld_r;
  result_t           out_res_r;
  logic              out_free;
  logic              res_vld;
  result_t           res;
  logic              rom_rd_en;
  logic [ROM_AW-1:0] rom_rd_addr;
  rom_entry_t        rom_rd_data;

  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (res_vld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  mkd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (thr_r),
    .key_vld     (in_tvalid),
    .key_pressed (in_tdata[0]),
    .key_rdy     (in_tready),
    .out_free    (out_free),
    .res_vld     (res_vld),
    .res         (res),
    .rom_rd_en   (rom_rd_en),
    .rom_rd_addr (rom_rd_addr),
    .rom_rd_data (rom_rd_data)
  );

  mkd_code_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r};

endmodule

// File: hw/rtl/mkd_checker.sv
// ----------------------------------------------------------------------------
// mkd_checker
// Port-level checks for the Morse key decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mkd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_letter_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("letter decoded while key held");

  a_letter_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[8:2] == 7'd0)
    else $error("letter nonzero without letter_valid");

  a_one_result_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tready)
    else $error("tick taken while result stalled");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
